// ===== design/sound_level_statistics_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sound level statistics: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_STATISTICS_CORE_DEFINES_SVH
`define SOUND_LEVEL_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sound level statistics check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sound level statistics check failed");

`endif

// ===== design/sls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound level statistics package
// Shared constants, codes, control structs and the threshold function.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int HIST_BINS_DEF          = 128;
    localparam int HIST_MIN_DB_DEF        = -120;
    localparam int HIST_STEP_TENTH_DB_DEF = 10;

    localparam logic [15:0] ATTACK_RESET   = 16'd11;
    localparam logic [15:0] DECAY_RESET    = 16'd11;
    localparam logic [23:0] WARMUP_RESET   = 24'd24000;
    localparam logic [23:0] INTERVAL_RESET = 24'd4800;

    // Operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Query status codes
    localparam logic [1:0] PST_FOUND = 2'd0;
    localparam logic [1:0] PST_EMPTY = 2'd1;
    localparam logic [1:0] PST_NEVER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ATTACK   = 2'd0;
    localparam logic [1:0] REG_DECAY    = 2'd1;
    localparam logic [1:0] REG_WARMUP   = 2'd2;
    localparam logic [1:0] REG_INTERVAL = 2'd3;

    localparam logic [31:0] TENTH_DB_DOWN_Q32 = 32'd4197201904;
    localparam logic [31:0] NEVER_THRESHOLD   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load_in;
        logic do_square;
        logic do_mult;
        logic do_update;
        logic scan_step;
        logic push_read;
        logic push_write;
        logic wipe_step;
        logic clear_stats;
        logic query_start;
        logic query_step;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       push_due;
        logic       scan_last;
        logic       idx_last;
        logic       idx_zero;
        logic       entries_zero;
        logic       query_hit;
        logic       out_free;
    } status_t;

    // Power threshold of bin k relative to full scale (2^30), rounded up.
    function automatic logic [31:0] sls_threshold(input int k, input int min_db,
                                                  input int step);
        int          m;
        logic [31:0] d;
        logic [63:0] v;
        logic [63:0] c;
        logic [63:0] t;
        m = 10 * min_db + k * step;
        v = 64'd1 << 62;
        c = {32'd0, TENTH_DB_DOWN_Q32};
        d = 32'(-m);
        if (m > 0)
        begin
            return NEVER_THRESHOLD;
        end
        for (int b = 0; b < 32; b++)
        begin
            if (d[b])
            begin
                v = (v >> 32) * c + (((v & 64'hFFFF_FFFF) * c) >> 32);
            end
            c = (c * c + 64'h8000_0000) >> 32;
        end
        t = (v + 64'hFFFF_FFFF) >> 32;
        if (t < 64'd1)
        begin
            t = 64'd1;
        end
        return t[31:0];
    endfunction

endpackage

// ===== design/sls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/sls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound level statistics controller
// Sequences square, detector update, histogram scan, clear and query steps.
// ----------------------------------------------------------------------------
module sls_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sls_pkg::status_t status,
    output sls_pkg::cmd_t   cmd
);
    import sls_pkg::*;

    localparam logic [3:0] S_WIPE    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SQUARE  = 4'd2;
    localparam logic [3:0] S_MULT    = 4'd3;
    localparam logic [3:0] S_UPDATE  = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_PUSH_RD = 4'd6;
    localparam logic [3:0] S_PUSH_WR = 4'd7;
    localparam logic [3:0] S_CLEAR   = 4'd8;
    localparam logic [3:0] S_QSTART  = 4'd9;
    localparam logic [3:0] S_QREAD   = 4'd10;
    localparam logic [3:0] S_QSTEP   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_WIPE:
            begin
                cmd.wipe_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    unique case (status.op)
                        OP_SAMPLE: state_next = S_SQUARE;
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_QUERY:  state_next = S_QSTART;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SQUARE:
            begin
                cmd.do_square = 1'b1;
                state_next    = S_MULT;
            end
            S_MULT:
            begin
                cmd.do_mult = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = status.push_due ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_PUSH_RD;
                end
            end
            S_PUSH_RD:
            begin
                cmd.push_read = 1'b1;
                state_next    = S_PUSH_WR;
            end
            S_PUSH_WR:
            begin
                cmd.push_write = 1'b1;
                state_next     = S_DONE;
            end
            S_CLEAR:
            begin
                cmd.wipe_step   = 1'b1;
                cmd.clear_stats = 1'b1;
                if (status.idx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_QSTART:
            begin
                cmd.query_start = 1'b1;
                state_next      = status.entries_zero ? S_DONE : S_QREAD;
            end
            S_QREAD:
            begin
                state_next = S_QSTEP;
            end
            S_QSTEP:
            begin
                cmd.query_step = 1'b1;
                state_next     = (status.query_hit || status.idx_zero) ? S_DONE : S_QREAD;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sls_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound level statistics datapath
// Detector, accumulators, extrema, histogram memory and output register.
// ----------------------------------------------------------------------------
module sls_datapath #(
    parameter int HIST_BINS          = sls_pkg::HIST_BINS_DEF,
    parameter int HIST_MIN_DB        = sls_pkg::HIST_MIN_DB_DEF,
    parameter int HIST_STEP_TENTH_DB = sls_pkg::HIST_STEP_TENTH_DB_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sls_pkg::cmd_t       cmd,
    output sls_pkg::status_t    status,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic [1:0]          operation,
    input  logic signed [15:0]  sample,
    input  logic [16:0]         exceeded_fraction,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [30:0]         detector_power,
    output logic                detector_valid,
    output logic [30:0]         max_power,
    output logic [30:0]         min_power,
    output logic                extrema_valid,
    output logic [63:0]         energy_sum,
    output logic [39:0]         sample_total,
    output logic [31:0]         hist_total,
    output logic [6:0]          percentile_bin,
    output logic [1:0]          percentile_status
);
    import sls_pkg::*;

    localparam int IW = $clog2(HIST_BINS);
    localparam int CW = 32 + IW;
    localparam int XW = CW + 16;
    localparam logic [IW-1:0] IDX_LAST = IW'(HIST_BINS - 1);

    // threshold table, fixed at elaboration
    logic [31:0] thr_tab [HIST_BINS];
    for (genvar k = 0; k < HIST_BINS; k++)
    begin : g_thr
        assign thr_tab[k] = sls_threshold(k, HIST_MIN_DB, HIST_STEP_TENTH_DB);
    end

    logic [15:0]        attack_reg, decay_reg;
    logic [23:0]        warmup_len_reg, interval_reg;
    logic signed [15:0] sample_reg;
    logic [16:0]        frac_reg;
    logic [30:0]        power_reg;
    logic [46:0]        prod_reg;
    logic               rise_reg;
    logic [30:0]        level_reg, peak_reg, floor_reg;
    logic               primed_reg, ext_primed_reg;
    logic [63:0]        energy_reg;
    logic [39:0]        count_reg;
    logic [23:0]        warmup_left_reg, countdown_reg;
    logic [31:0]        entries_reg;
    logic [IW-1:0]      idx_reg, bin_sel_reg;
    logic [48:0]        target_reg;
    logic [CW-1:0]      cum_reg;
    logic [6:0]         pct_bin_reg;
    logic [1:0]         pct_status_reg;
    logic               out_valid_reg;

    logic signed [31:0] square;
    logic               rise;
    logic [30:0]        diff;
    logic [15:0]        coef;
    logic [46:0]        round_sum;
    logic [30:0]        level_next;
    logic [64:0]        energy_wide;
    logic [31:0]        bin_count_inc;
    logic [CW-1:0]      cum_next;
    logic               hit;
    logic               thr_hit;

    logic               ram_we;
    logic [IW-1:0]      ram_wr_addr, ram_rd_addr;
    logic [31:0]        ram_wr_data, ram_rd_data;

    sls_ram #(
        .WIDTH (32),
        .DEPTH (HIST_BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign square    = sample_reg * sample_reg;
    assign rise      = power_reg > level_reg;
    assign diff      = rise ? (power_reg - level_reg) : (level_reg - power_reg);
    assign coef      = rise ? attack_reg : decay_reg;
    assign round_sum = prod_reg + 47'd32768;

    always_comb
    begin
        if (!primed_reg)
        begin
            level_next = power_reg;
        end
        else if (rise_reg)
        begin
            level_next = level_reg + round_sum[46:16];
        end
        else
        begin
            level_next = level_reg - round_sum[46:16];
        end
    end

    assign energy_wide   = {1'b0, energy_reg} + 65'(power_reg);
    assign bin_count_inc = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 32'd1;
    assign cum_next      = cum_reg + CW'(ram_rd_data);
    assign hit           = {cum_next, 16'd0} >= XW'(target_reg);
    assign thr_hit       = {1'b0, level_reg} >= thr_tab[idx_reg];

    assign ram_we      = cmd.wipe_step | cmd.push_write;
    assign ram_wr_addr = cmd.push_write ? bin_sel_reg : idx_reg;
    assign ram_wr_data = cmd.push_write ? bin_count_inc : 32'd0;
    assign ram_rd_addr = cmd.push_read ? bin_sel_reg : idx_reg;

    assign status.op           = operation;
    assign status.push_due     = (countdown_reg <= 24'd1);
    assign status.scan_last    = (idx_reg == IDX_LAST);
    assign status.idx_last     = (idx_reg == IDX_LAST);
    assign status.idx_zero     = (idx_reg == '0);
    assign status.entries_zero = (entries_reg == 32'd0);
    assign status.query_hit    = hit;
    assign status.out_free     = !out_valid_reg || !out_stall;

    // control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg      <= ATTACK_RESET;
            decay_reg       <= DECAY_RESET;
            warmup_len_reg  <= WARMUP_RESET;
            interval_reg    <= INTERVAL_RESET;
            level_reg       <= '0;
            primed_reg      <= 1'b0;
            energy_reg      <= '0;
            count_reg       <= '0;
            peak_reg        <= '0;
            floor_reg       <= '0;
            ext_primed_reg  <= 1'b0;
            warmup_left_reg <= WARMUP_RESET;
            countdown_reg   <= INTERVAL_RESET;
            entries_reg     <= '0;
            idx_reg         <= '0;
            bin_sel_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ATTACK:   attack_reg     <= cfg_data[15:0];
                    REG_DECAY:    decay_reg      <= cfg_data[15:0];
                    REG_WARMUP:   warmup_len_reg <= cfg_data;
                    REG_INTERVAL: interval_reg   <= cfg_data;
                    default:      ;
                endcase
            end

            if (cmd.load_in)
            begin
                idx_reg <= '0;
            end

            if (cmd.do_update)
            begin
                level_reg  <= level_next;
                primed_reg <= 1'b1;
                energy_reg <= energy_wide[64] ? '1 : energy_wide[63:0];
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + 40'd1;
                end
                if (warmup_left_reg != '0)
                begin
                    warmup_left_reg <= warmup_left_reg - 24'd1;
                end
                else if (!ext_primed_reg)
                begin
                    peak_reg       <= level_next;
                    floor_reg      <= level_next;
                    ext_primed_reg <= 1'b1;
                end
                else
                begin
                    if (level_next > peak_reg)
                    begin
                        peak_reg <= level_next;
                    end
                    if (level_next < floor_reg)
                    begin
                        floor_reg <= level_next;
                    end
                end
                countdown_reg <= (countdown_reg <= 24'd1) ? interval_reg
                                                          : countdown_reg - 24'd1;
                idx_reg       <= IW'(1);
                bin_sel_reg   <= '0;
            end

            // count thresholds at or below the level
            if (cmd.scan_step)
            begin
                bin_sel_reg <= bin_sel_reg + IW'(thr_hit);
                idx_reg     <= idx_reg + IW'(1);
            end

            if (cmd.push_write && entries_reg != '1)
            begin
                entries_reg <= entries_reg + 32'd1;
            end

            if (cmd.wipe_step)
            begin
                idx_reg <= idx_reg + IW'(1);
            end

            if (cmd.clear_stats)
            begin
                energy_reg      <= '0;
                count_reg       <= '0;
                peak_reg        <= '0;
                floor_reg       <= '0;
                ext_primed_reg  <= 1'b0;
                warmup_left_reg <= warmup_len_reg;
                countdown_reg   <= interval_reg;
                entries_reg     <= '0;
            end

            if (cmd.query_start)
            begin
                idx_reg <= IDX_LAST;
            end

            if (cmd.query_step)
            begin
                idx_reg <= idx_reg - IW'(1);
            end

            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg     <= sample;
            frac_reg       <= exceeded_fraction;
            pct_bin_reg    <= '0;
            pct_status_reg <= PST_FOUND;
        end
        if (cmd.do_square)
        begin
            power_reg <= square[30:0];
        end
        if (cmd.do_mult)
        begin
            prod_reg <= coef * diff;
            rise_reg <= rise;
        end
        if (cmd.query_start)
        begin
            target_reg <= frac_reg * entries_reg;
            cum_reg    <= '0;
            if (entries_reg == 32'd0)
            begin
                pct_status_reg <= PST_EMPTY;
            end
        end
        if (cmd.query_step)
        begin
            cum_reg <= cum_next;
            if (hit)
            begin
                pct_bin_reg    <= 7'(idx_reg);
                pct_status_reg <= PST_FOUND;
            end
            else if (idx_reg == '0)
            begin
                pct_status_reg <= PST_NEVER;
            end
        end
        if (cmd.result_load)
        begin
            detector_power    <= level_reg;
            detector_valid    <= primed_reg;
            max_power         <= peak_reg;
            min_power         <= floor_reg;
            extrema_valid     <= ext_primed_reg;
            energy_sum        <= energy_reg;
            sample_total      <= count_reg;
            hist_total        <= entries_reg;
            percentile_bin    <= pct_bin_reg;
            percentile_status <= pct_status_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/sound_level_statistics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound level statistics core
// Power detector, Leq energy sum, extrema and level histogram with query.
// ----------------------------------------------------------------------------
// The block takes one item at a time and answers each with one result. A
// sample item passes from acceptance to the output register through square,
// coefficient multiply, update and hand-off; when the histogram interval
// expires it also walks the threshold table one bin per cycle and then
// read-modify-writes the bin memory. A clear makes one bin memory write per
// cycle. A query walks the bins from the highest down: each bin costs one
// registered memory read and one accumulate. After reset the bin memory is
// swept to zero while input stays stalled; configuration writes are taken at
// any time. A finished result waits in the output register, so the next item
// is taken while it is still held.
// ----------------------------------------------------------------------------
module sound_level_statistics_core #(
    parameter int HIST_BINS          = sls_pkg::HIST_BINS_DEF,
    parameter int HIST_MIN_DB        = sls_pkg::HIST_MIN_DB_DEF,
    parameter int HIST_STEP_TENTH_DB = sls_pkg::HIST_STEP_TENTH_DB_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic signed [15:0] sample,
    input  logic [16:0]        exceeded_fraction,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        detector_power,
    output logic               detector_valid,
    output logic [30:0]        max_power,
    output logic [30:0]        min_power,
    output logic               extrema_valid,
    output logic [63:0]        energy_sum,
    output logic [39:0]        sample_total,
    output logic [31:0]        hist_total,
    output logic [6:0]         percentile_bin,
    output logic [1:0]         percentile_status
);
    import sls_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequence each item's steps
    sls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // hold all statistics and the bin memory
    sls_datapath #(
        .HIST_BINS          (HIST_BINS),
        .HIST_MIN_DB        (HIST_MIN_DB),
        .HIST_STEP_TENTH_DB (HIST_STEP_TENTH_DB)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .sample            (sample),
        .exceeded_fraction (exceeded_fraction),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .detector_power    (detector_power),
        .detector_valid    (detector_valid),
        .max_power         (max_power),
        .min_power         (min_power),
        .extrema_valid     (extrema_valid),
        .energy_sum        (energy_sum),
        .sample_total      (sample_total),
        .hist_total        (hist_total),
        .percentile_bin    (percentile_bin),
        .percentile_status (percentile_status)
    );

endmodule

// ===== design/sls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound level statistics port checker
// Checks result consistency and handshake behaviour seen at the ports.
// ----------------------------------------------------------------------------
`include "sound_level_statistics_core_defines.svh"

module sls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [30:0] detector_power,
    input logic [30:0] max_power,
    input logic [30:0] min_power,
    input logic        extrema_valid,
    input logic [1:0]  percentile_status
);

    // an accepted item leaves the block busy in the cycle after acceptance
    `SLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // hold a stalled result
    `SLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(detector_power) && $stable(max_power))

    // extrema read zero before tracking starts
    `SLS_ASSERT_SAME(a_extrema_idle, clk, rst_n, out_valid && !extrema_valid,
                     max_power == 31'd0 && min_power == 31'd0)

    // floor never above peak, status code in range
    `SLS_ASSERT_SAME(a_extrema_order, clk, rst_n, out_valid && extrema_valid,
                     min_power <= max_power && percentile_status != 2'd3)

endmodule

bind sound_level_statistics_core sls_checker u_sls_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound level statistics core testbench
// Drives random and directed sample, clear and query items under several
// register settings. A local model of the detector, statistics and level
// histogram predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import sls_pkg::*;

    localparam int NBINS      = HIST_BINS_DEF;
    // Worst single item is a query: a memory read and an accumulate per bin.
    localparam int DRAIN      = 2 * NBINS + 50;
    localparam int IDLE_LIMIT = 6000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] smp;
        logic [16:0] frac;
    } item_t;

    typedef struct {
        logic [30:0] det;
        logic        det_ok;
        logic [30:0] maxp;
        logic [30:0] minp;
        logic        ext_ok;
        logic [63:0] energy;
        logic [39:0] count;
        logic [31:0] entries;
        logic [6:0]  bin;
        logic [1:0]  status;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_ATTACK;
    logic [23:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] operation = OP_SAMPLE;
    logic signed [15:0] sample = '0;
    logic [16:0] exceeded_fraction = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [30:0] detector_power;
    logic detector_valid;
    logic [30:0] max_power;
    logic [30:0] min_power;
    logic extrema_valid;
    logic [63:0] energy_sum;
    logic [39:0] sample_total;
    logic [31:0] hist_total;
    logic [6:0] percentile_bin;
    logic [1:0] percentile_status;

    sound_level_statistics_core dut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Local model state
    // ------------------------------------------------------------------
    logic [15:0] attack_q, decay_q;
    logic [23:0] warmup_q, interval_q;
    logic [31:0] level_q;
    logic        level_primed;
    logic [63:0] energy_q;
    logic [39:0] count_q;
    logic [31:0] peak_q, floor_q;
    logic        extrema_primed;
    logic [23:0] warmup_left, countdown_q;
    logic [31:0] bin_count [NBINS];
    logic [31:0] entries_q;
    logic [31:0] bin_floor [NBINS];

    item_t  pending_items [$];
    stats_t expected_stats [$];
    int errors = 0;
    int n_samples = 0, n_queries = 0, n_clears = 0, n_spare = 0, n_phases = 0;
    bit idling_on = 1'b1;

    // Lowest power that falls into bin k, rounded up; unreachable above 0 dB.
    function automatic logic [31:0] power_floor_of_bin(int k);
        int m;
        longint unsigned v, c, t;
        int unsigned d;
        m = 10 * HIST_MIN_DB_DEF + k * HIST_STEP_TENTH_DB_DEF;
        if (m > 0)
            return 32'hFFFF_FFFF;
        d = -m;
        v = 64'd1 << 62;
        c = 64'd4197201904;
        while (d != 0)
        begin
            if (d[0])
                v = (v >> 32) * c + (((v & 64'hFFFF_FFFF) * c) >> 32);
            c = (c * c + 64'h8000_0000) >> 32;
            d = d >> 1;
        end
        t = (v + 64'hFFFF_FFFF) >> 32;
        if (t == 0)
            t = 1;
        return t[31:0];
    endfunction

    function automatic void wipe_statistics();
        energy_q = '0;
        count_q = '0;
        peak_q = '0;
        floor_q = '0;
        extrema_primed = 1'b0;
        warmup_left = warmup_q;
        countdown_q = interval_q;
        entries_q = '0;
        for (int i = 0; i < NBINS; i++)
            bin_count[i] = '0;
    endfunction

    function automatic void record_level();
        int idx;
        idx = 0;
        for (int k = 1; k < NBINS; k++)
            if (level_q >= bin_floor[k])
                idx = k;
        if (bin_count[idx] != 32'hFFFF_FFFF)
            bin_count[idx]++;
        if (entries_q != 32'hFFFF_FFFF)
            entries_q++;
    endfunction

    function automatic void absorb_sample(logic signed [15:0] s);
        longint signed sv;
        longint unsigned p, diff, step;
        sv = s;
        p = sv * sv;
        if (!level_primed)
        begin
            level_q = p[31:0];
            level_primed = 1'b1;
        end
        else if (p > level_q)
        begin
            diff = p - level_q;
            step = (attack_q * diff + 32768) >> 16;
            level_q = level_q + step[31:0];
        end
        else
        begin
            diff = level_q - p;
            step = (decay_q * diff + 32768) >> 16;
            level_q = level_q - step[31:0];
        end
        if (energy_q > 64'hFFFF_FFFF_FFFF_FFFF - p)
            energy_q = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            energy_q = energy_q + p;
        if (count_q != 40'hFF_FFFF_FFFF)
            count_q++;
        if (warmup_left > 0)
            warmup_left--;
        else if (!extrema_primed)
        begin
            peak_q = level_q;
            floor_q = level_q;
            extrema_primed = 1'b1;
        end
        else
        begin
            if (level_q > peak_q)
                peak_q = level_q;
            if (level_q < floor_q)
                floor_q = level_q;
        end
        // An interval of zero behaves as one.
        if (countdown_q <= 1)
        begin
            countdown_q = interval_q;
            record_level();
        end
        else
            countdown_q--;
    endfunction

    // Walk the bins from the loudest down until the exceeded share is met.
    function automatic void find_percentile(logic [16:0] frac, output logic [6:0] bin,
                                            output logic [1:0] status);
        longint unsigned target, cum;
        bin = '0;
        status = PST_NEVER;
        target = longint'(frac) * entries_q;
        cum = 0;
        if (entries_q == 0)
        begin
            status = PST_EMPTY;
            return;
        end
        for (int i = NBINS - 1; i >= 0; i--)
        begin
            cum += bin_count[i];
            if ((cum << 16) >= target)
            begin
                bin = i[6:0];
                status = PST_FOUND;
                return;
            end
        end
    endfunction

    function automatic stats_t advance_statistics(item_t it);
        stats_t r;
        r.bin = '0;
        r.status = PST_FOUND;
        case (it.op)
            OP_SAMPLE: absorb_sample(it.smp);
            OP_CLEAR:  wipe_statistics();
            OP_QUERY:  find_percentile(it.frac, r.bin, r.status);
            default:   ;
        endcase
        r.det = level_q[30:0];
        r.det_ok = level_primed;
        r.maxp = peak_q[30:0];
        r.minp = floor_q[30:0];
        r.ext_ok = extrema_primed;
        r.energy = energy_q;
        r.count = count_q;
        r.entries = entries_q;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: while idling is on, present pending items with random gaps between them
    // ------------------------------------------------------------------
    int gap_left = 0;
    always @(posedge clk)
    begin
        item_t it;
        logic nv;
        if (rst_n)
        begin
            nv = in_valid;
            if (in_valid && !in_stall)
            begin
                expected_stats.push_back(advance_statistics('{operation, sample,
                                                               exceeded_fraction}));
                nv = 1'b0;
                gap_left = idling_on ? $urandom_range(0, 7) : 0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    operation <= it.op;
                    sample <= it.smp;
                    exceeded_fraction <= it.frac;
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure while idling is on, field-by-field comparison
    // ------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    errors++;
                    $display("%0t: result item with nothing expected", $realtime);
                end
                else
                begin
                    e = expected_stats.pop_front();
                    if (detector_power !== e.det)
                        report_mismatch("detector_power", detector_power, e.det);
                    if (detector_valid !== e.det_ok)
                        report_mismatch("detector_valid", detector_valid, e.det_ok);
                    if (max_power !== e.maxp)
                        report_mismatch("max_power", max_power, e.maxp);
                    if (min_power !== e.minp)
                        report_mismatch("min_power", min_power, e.minp);
                    if (extrema_valid !== e.ext_ok)
                        report_mismatch("extrema_valid", extrema_valid, e.ext_ok);
                    if (energy_sum !== e.energy)
                        report_mismatch("energy_sum", energy_sum, e.energy);
                    if (sample_total !== e.count)
                        report_mismatch("sample_total", sample_total, e.count);
                    if (hist_total !== e.entries)
                        report_mismatch("hist_total", hist_total, e.entries);
                    if (percentile_bin !== e.bin)
                        report_mismatch("percentile_bin", percentile_bin, e.bin);
                    if (percentile_status !== e.status)
                        report_mismatch("percentile_status", percentile_status, e.status);
                end
                stall_left = idling_on ? $urandom_range(0, 7) : 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: abandon the run if nothing moves for too long.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(logic [1:0] op, logic [15:0] s, logic [16:0] f);
        pending_items.push_back('{op, s, f});
        case (op)
            OP_SAMPLE: n_samples++;
            OP_CLEAR:  n_clears++;
            OP_QUERY:  n_queries++;
            default:   n_spare++;
        endcase
    endtask

    // Hold until everything queued has been answered and the core is quiet.
    task automatic wait_quiet();
        while (pending_items.size() != 0 || in_valid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [23:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_ATTACK:   attack_q = value[15:0];
            REG_DECAY:    decay_q = value[15:0];
            REG_WARMUP:   warmup_q = value;
            REG_INTERVAL: interval_q = value;
            default:      ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_registers(logic [15:0] a, logic [15:0] d, logic [23:0] w,
                                 logic [23:0] h);
        write_register(REG_ATTACK, {8'd0, a});
        write_register(REG_DECAY, {8'd0, d});
        write_register(REG_WARMUP, w);
        write_register(REG_INTERVAL, h);
    endtask

    // Samples spread over the whole dB range: random magnitude, random sign.
    function automatic logic [15:0] spread_sample();
        int mag;
        mag = $urandom_range(0, 32767) >> $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'h8000;
            default: return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
        endcase
    endfunction

    function automatic logic [16:0] random_fraction();
        case ($urandom_range(0, 7))
            0:       return 17'($urandom);
            1:       return 17'd65536;
            2:       return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        queue_item(OP_CLEAR, 16'($urandom), 17'($urandom));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 84)
                queue_item(OP_SAMPLE, spread_sample(), 17'($urandom));
            else if (r < 94)
                queue_item(OP_QUERY, 16'($urandom), random_fraction());
            else if (r < 97)
                queue_item(OP_CLEAR, 16'($urandom), 17'($urandom));
            else
                queue_item(2'd3, 16'($urandom), 17'($urandom));
        end
        wait_quiet();
        n_phases++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < NBINS; k++)
            bin_floor[k] = power_floor_of_bin(k);
        attack_q = ATTACK_RESET;
        decay_q = DECAY_RESET;
        warmup_q = WARMUP_RESET;
        interval_q = INTERVAL_RESET;
        level_q = '0;
        level_primed = 1'b0;
        wipe_statistics();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: empty histogram, priming, spare opcode.
        queue_item(OP_QUERY, 16'h0000, 17'd32768);
        queue_item(2'd3, 16'hFFFF, 17'h1FFFF);
        queue_item(OP_SAMPLE, 16'h8000, 17'd0);
        queue_item(OP_SAMPLE, 16'h7FFF, 17'd0);
        queue_item(OP_SAMPLE, 16'h0000, 17'd0);
        queue_item(OP_SAMPLE, 16'hFFFF, 17'd0);
        queue_item(OP_SAMPLE, 16'h0001, 17'd0);
        queue_item(OP_CLEAR, 16'h0000, 17'd0);
        wait_quiet();

        // Directed, fastest attack, no decay and a histogram entry per sample.
        set_registers(16'hFFFF, 16'h0000, 24'd0, 24'd1);
        queue_item(OP_CLEAR, 16'h0000, 17'd0);
        queue_item(OP_SAMPLE, 16'h8000, 17'd0);
        queue_item(OP_SAMPLE, 16'h0001, 17'd0);
        queue_item(OP_SAMPLE, 16'h0000, 17'd0);
        queue_item(OP_SAMPLE, 16'h7FFF, 17'd0);
        queue_item(OP_SAMPLE, 16'hFF00, 17'd0);
        queue_item(OP_QUERY, 16'h0000, 17'd0);
        queue_item(OP_QUERY, 16'h0000, 17'd1);
        queue_item(OP_QUERY, 16'h0000, 17'd32768);
        queue_item(OP_QUERY, 16'h0000, 17'd65535);
        queue_item(OP_QUERY, 16'h0000, 17'd65536);
        queue_item(OP_QUERY, 16'h0000, 17'd65537);
        queue_item(OP_QUERY, 16'h0000, 17'h1FFFF);
        wait_quiet();

        // Random phases over a spread of settings; idling off in the second and fourth.
        set_registers(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        random_phase(200);
        idling_on = 1'b0;
        set_registers(16'h0000, 16'h0000, 24'd3, 24'd2);
        random_phase(200);
        idling_on = 1'b1;
        set_registers(16'($urandom), 16'($urandom), 24'd0, 24'd0);
        random_phase(200);
        idling_on = 1'b0;
        set_registers(16'($urandom), 16'($urandom), 24'($urandom_range(0, 20)),
                      24'($urandom_range(1, 5)));
        random_phase(200);
        idling_on = 1'b1;
        set_registers(16'd32768, 16'd4096, 24'd1, 24'd1);
        random_phase(200);
        set_registers(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                      24'($urandom_range(0, 50)), 24'($urandom_range(1, 3)));
        random_phase(200);
        set_registers(ATTACK_RESET, DECAY_RESET, 24'd10, 24'd3);
        random_phase(200);

        wait_quiet();
        $display("Covered %0d samples, %0d queries, %0d clears, %0d spare opcodes",
                 n_samples, n_queries, n_clears, n_spare);
        $display("over %0d random register settings plus directed cases; %0d mismatches",
                 n_phases, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
